// ===== hdl/sdes_pkg.sv =====
// Shared types, constants and S-DES permutation, S-box and key schedule functions.
// Used by every module of the byte encryptor; depends on nothing.
package sdes_pkg;

  localparam int KEY_W  = 10;
  localparam int BYTE_W = 8;
  localparam int HALF_W = 4;
  localparam int SUB_W  = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Two-entry queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Register map: word index lives in paddr[ADDR_W-1]
  localparam logic KEY_INDEX = 1'b0;

  typedef struct packed {
    logic [SUB_W-1:0] k1;
    logic [SUB_W-1:0] k2;
  } sdes_subkeys_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } sdes_word_t;

  // S-box tables, indexed by {row, col}
  localparam logic [1:0] S0_TAB [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] S1_TAB [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  function automatic logic [KEY_W-1:0] p10(input logic [KEY_W-1:0] v);
    return {v[7], v[5], v[8], v[3], v[6], v[0], v[9], v[1], v[2], v[4]};
  endfunction

  function automatic logic [SUB_W-1:0] p8(input logic [KEY_W-1:0] v);
    return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
  endfunction

  function automatic logic [BYTE_W-1:0] ip(input logic [BYTE_W-1:0] v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  function automatic logic [BYTE_W-1:0] ipinv(input logic [BYTE_W-1:0] v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic logic [SUB_W-1:0] ep(input logic [HALF_W-1:0] v);
    return {v[0], v[3], v[2], v[1], v[2], v[1], v[0], v[3]};
  endfunction

  function automatic logic [HALF_W-1:0] p4(input logic [HALF_W-1:0] v);
    return {v[2], v[0], v[1], v[3]};
  endfunction

  // Row from outer bits, column from inner bits
  function automatic logic [1:0] s0_look(input logic [HALF_W-1:0] b);
    return S0_TAB[{b[3], b[0], b[2:1]}];
  endfunction

  function automatic logic [1:0] s1_look(input logic [HALF_W-1:0] b);
    return S1_TAB[{b[3], b[0], b[2:1]}];
  endfunction

  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                input logic [SUB_W-1:0]  sub);
    logic [SUB_W-1:0] e;
    e = ep(half) ^ sub;
    return p4({s0_look(e[7:4]), s1_look(e[3:0])});
  endfunction

  // K1 after one left rotate of each half, K2 after three
  function automatic sdes_subkeys_t key_sched(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] p;
    logic [4:0]       hi;
    logic [4:0]       lo;
    sdes_subkeys_t    ks;
    p     = p10(key);
    hi    = p[9:5];
    lo    = p[4:0];
    ks.k1 = p8({hi[3:0], hi[4], lo[3:0], lo[4]});
    ks.k2 = p8({hi[1:0], hi[4:2], lo[1:0], lo[4:2]});
    return ks;
  endfunction

endpackage

// ===== hdl/sdes_byte_encrypt_top.sv =====
// Top level of the S-DES byte encryptor: register port, key schedule and datapath.
// Depends on sdes_pkg, sdes_front, sdes_queue and sdes_back.
//
//   channel  dir  handshake            payload
//   -------  ---  -------------------  ------------------
//   input    in   in_valid / in_stall  plain_byte[7:0]
//   output   out  out_valid/out_stall  cipher_byte[7:0]
//   config   in   APB psel/penable     cipher_key @ 0x0
//
// One word enters per cycle when the result side keeps up; an accepted word leaves
// through the front register, a queue entry, round one and round two (output register).
// Throughput when unstalled is set by the one-word-per-cycle front and output registers.
// Reset (synchronous, rst high) empties every stage and clears the key to zero.
// A stalled result holds in the output register while round one, the queue and
// the front keep taking words until all fill; in_stall then rises.
module sdes_byte_encrypt_top (
  input  logic                        clk,
  input  logic                        rst,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdes_pkg::ADDR_W-1:0] paddr,
  input  logic [sdes_pkg::DATA_W-1:0] pwdata,
  output logic [sdes_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // plaintext channel
  input  logic                        in_valid,
  input  logic [sdes_pkg::BYTE_W-1:0] plain_byte,
  output logic                        in_stall,
  // ciphertext channel
  output logic                        out_valid,
  output logic [sdes_pkg::BYTE_W-1:0] cipher_byte,
  input  logic                        out_stall
);

  logic [sdes_pkg::KEY_W-1:0] cipher_key;
  sdes_pkg::sdes_subkeys_t    subkeys;
  logic                       key_sel;
  logic                       key_wr;
  sdes_pkg::sdes_word_t       push;
  sdes_pkg::sdes_word_t       head;
  logic                       q_full;
  logic                       pop;

  // Register port: no wait states, word index taken from the top address bit
  assign pready  = 1'b1;
  assign key_sel = (paddr[sdes_pkg::ADDR_W-1] == sdes_pkg::KEY_INDEX);
  assign key_wr  = psel & penable & pwrite & pready & key_sel;

  always_comb begin
    prdata = '0;
    if (key_sel) begin
      prdata = sdes_pkg::DATA_W'(cipher_key);
    end
  end

  // Hold the key and its two subkeys; refresh both on a key write.
  // Subkeys of an all-zero key are zero, so reset clears them too.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      subkeys    <= '0;
    end else if (key_wr) begin
      cipher_key <= pwdata[sdes_pkg::KEY_W-1:0];
      subkeys    <= sdes_pkg::key_sched(pwdata[sdes_pkg::KEY_W-1:0]);
    end
  end

  // Front: take the plaintext word and apply the initial permutation
  sdes_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .plain_byte (plain_byte),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push)
  );

  // Queue: absorb result-side stalls so the front can keep accepting
  sdes_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  // Back: two Feistel rounds and the final permutation
  sdes_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .subkeys     (subkeys),
    .pop         (pop),
    .out_valid   (out_valid),
    .cipher_byte (cipher_byte),
    .out_stall   (out_stall)
  );

  // Subkeys always track the key written last
  a_subkeys_follow_key: assert property (@(posedge clk) disable iff (rst)
    key_wr |=> (subkeys == sdes_pkg::key_sched(cipher_key)))
    else $error("subkeys do not match the written key");

  // An accepted word is held in the front register on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> push.valid || in_stall)
    else $error("accepted word lost in front stage");

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall && !head.valid))
    else $error("block not empty after reset");

endmodule

// ===== hdl/sdes_front.sv =====
// Front stage: accepts plaintext words and applies the initial permutation.
// Depends on sdes_pkg; feeds sdes_queue.
module sdes_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [sdes_pkg::BYTE_W-1:0] plain_byte,
  output logic                       in_stall,
  input  logic                       q_full,
  output sdes_pkg::sdes_word_t       push
);

  logic                        front_valid;
  logic                        front_valid_next;
  logic [sdes_pkg::BYTE_W-1:0] front_data;
  logic                        accept;

  assign in_stall   = front_valid & q_full;
  assign accept     = in_valid & ~in_stall;
  assign push.valid = front_valid & ~q_full;
  assign push.data  = front_data;

  always_comb begin
    front_valid_next = front_valid;
    if (accept) begin
      front_valid_next = 1'b1;
    end else if (push.valid) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_data <= sdes_pkg::ip(plain_byte);
    end
  end

endmodule

// ===== hdl/sdes_queue.sv =====
// Two-entry queue that decouples the front stage from the round pipeline.
// Depends on sdes_pkg.
module sdes_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  sdes_pkg::sdes_word_t push,
  input  logic                 pop,
  output sdes_pkg::sdes_word_t head,
  output logic                 full
);

  logic [sdes_pkg::BYTE_W-1:0] entries [sdes_pkg::QUEUE_DEPTH];
  logic [sdes_pkg::QPTR_W-1:0] wr_ptr;
  logic [sdes_pkg::QPTR_W-1:0] rd_ptr;
  logic [sdes_pkg::QCNT_W-1:0] count;
  logic [sdes_pkg::QCNT_W-1:0] count_next;
  logic                        do_pop;

  assign full       = (count == sdes_pkg::QCNT_W'(sdes_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.data  = entries[rd_ptr];
  assign do_pop     = pop & head.valid;

  always_comb begin
    count_next = count;
    case ({push.valid, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.data;
    end
  end

endmodule

// ===== hdl/sdes_back.sv =====
// Back pipeline: Feistel round one, then round two with the inverse permutation.
// Depends on sdes_pkg; drains sdes_queue and drives the result channel.
module sdes_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sdes_pkg::sdes_word_t        head,
  input  sdes_pkg::sdes_subkeys_t     subkeys,
  output logic                        pop,
  output logic                        out_valid,
  output logic [sdes_pkg::BYTE_W-1:0] cipher_byte,
  input  logic                        out_stall
);

  logic                        s1_valid;
  logic [sdes_pkg::HALF_W-1:0] s1_l1;
  logic [sdes_pkg::HALF_W-1:0] s1_r;
  logic                        out_adv;
  logic                        s1_adv;
  logic [sdes_pkg::HALF_W-1:0] l1;
  logic [sdes_pkg::HALF_W-1:0] l2;

  assign out_adv = ~out_valid | ~out_stall;
  assign s1_adv  = ~s1_valid | out_adv;
  assign pop     = head.valid & s1_adv;

  assign l1 = head.data[7:4] ^ sdes_pkg::round_f(head.data[3:0], subkeys.k1);
  assign l2 = s1_r ^ sdes_pkg::round_f(s1_l1, subkeys.k2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= head.valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_l1 <= l1;
      s1_r  <= head.data[3:0];
    end
    if (out_adv & s1_valid) begin
      cipher_byte <= sdes_pkg::ipinv({l2, s1_l1});
    end
  end

endmodule
